### rtl/core/sbap_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sbap_pkg
// Constants and the armor mapping shared by the six-bit armor packer.
// ---------------------------------------------------------------------------
package sbap_pkg;

  localparam int VALUE_BITS          = 32;   // width of the field value port
  localparam int WIDTH_BITS          = 6;    // width of the field width port
  localparam int GROUP_BITS          = 6;    // bits per armored character
  localparam int PEND_BITS           = 5;    // pending bits carried between items
  localparam int PCNT_BITS           = 3;    // pending count width
  localparam int CHAR_BITS           = 7;
  localparam int FILL_BITS           = 3;
  localparam int DEF_MAX_FIELD_BITS  = 32;

  localparam logic [GROUP_BITS-1:0] ARMOR_SPLIT = 6'h28;
  localparam logic [CHAR_BITS-1:0]  ARMOR_LOW   = 7'h30;
  localparam logic [CHAR_BITS-1:0]  ARMOR_HIGH  = 7'h38;

  // six-bit group to armored ASCII
  function automatic logic [CHAR_BITS-1:0] armor(input logic [GROUP_BITS-1:0] grp);
    logic [CHAR_BITS-1:0] g;
    g = {1'b0, grp};
    if (grp < ARMOR_SPLIT) begin
      armor = g + ARMOR_LOW;
    end else begin
      armor = g + ARMOR_HIGH;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/core/six_bit_ascii_armor_packer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// six_bit_ascii_armor_packer
// Packs MSB-first bit fields into six-bit ASCII armor characters.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one item is one bit field, its width
//   (clamped to MAX_FIELD_BITS, at most 32) and a last-field flag.
//   Result channel (out_valid/out_ready): zero to seven armored characters
//   per item. The last character of a message carries message_end and the
//   number of zero pad bits in fill_bits; fill_bits is 0 elsewhere.
//   A field that completes no group and is not final yields no result.
// Pipeline and throughput
//   An item passes the input register, then the character shifter, which
//   feeds the output register. The input register takes the next item
//   while the shifter still works on the last one. The shifter emits one
//   character per cycle into the output register while that register is
//   free or draining.
// Reset
//   rst_n (synchronous, active low) empties all stages and clears the
//   partial group held between items.
// Stall
//   While out_ready is low the output register holds; the shifter and the
//   input register fill up, after which in_ready drops.
// ---------------------------------------------------------------------------
module six_bit_ascii_armor_packer #(
  parameter int MAX_FIELD_BITS = sbap_pkg::DEF_MAX_FIELD_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sbap_pkg::VALUE_BITS-1:0]  in_field_value,
  input  wire logic [sbap_pkg::WIDTH_BITS-1:0]  in_field_width,
  input  wire logic                             in_final_field,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [sbap_pkg::CHAR_BITS-1:0]        out_armored_char,
  output logic [sbap_pkg::FILL_BITS-1:0]        out_fill_bits,
  output logic                                  out_message_end
);

  // Bits taken from a field at most
  localparam int LIMIT = (MAX_FIELD_BITS < sbap_pkg::VALUE_BITS) ? MAX_FIELD_BITS
                                                                  : sbap_pkg::VALUE_BITS;
  // Pending bits plus one field
  localparam int CW    = LIMIT + sbap_pkg::PEND_BITS;
  // Shifter width, whole groups
  localparam int NGRP  = (CW + sbap_pkg::GROUP_BITS - 1) / sbap_pkg::GROUP_BITS;
  localparam int BUFW  = NGRP * sbap_pkg::GROUP_BITS;
  localparam int SW    = $clog2(BUFW + 1);
  localparam int CNTW  = $clog2(NGRP + 1);
  localparam int G     = sbap_pkg::GROUP_BITS;
  // floor(x/6) as (x*43)>>8, exact for x below 64
  localparam int RECIP = 43;
  localparam int PW    = SW + 6;

  // ---- input register --------------------------------------------------
  logic                                a_valid_r;
  logic [sbap_pkg::VALUE_BITS-1:0]     a_value_r;
  logic [sbap_pkg::WIDTH_BITS-1:0]     a_width_r;
  logic                                a_final_r;

  // ---- partial group carried between items --------------------------------
  logic [sbap_pkg::PEND_BITS-1:0]      pend_bits_r, pend_bits_nxt;
  logic [sbap_pkg::PCNT_BITS-1:0]      pend_cnt_r,  pend_cnt_nxt;

  // ---- character shifter -----------------------------------------------
  logic [BUFW-1:0]                     b_word_r;
  logic [CNTW-1:0]                     b_left_r;
  logic                                b_final_r;
  logic [sbap_pkg::FILL_BITS-1:0]      b_fill_r;

  // ---- output register -------------------------------------------------
  logic                                out_valid_r;
  logic [sbap_pkg::CHAR_BITS-1:0]      out_char_r;
  logic [sbap_pkg::FILL_BITS-1:0]      out_fill_r;
  logic                                out_end_r;

  logic b_emit, b_free, a_load;

  // Emit from the shifter whenever the output register is free or draining
  assign b_emit   = (b_left_r != '0) && (!out_valid_r || out_ready);
  assign b_free   = (b_left_r == '0) ||
                    ((b_left_r == CNTW'(1)) && b_emit);
  assign a_load   = a_valid_r && b_free;
  assign in_ready = !a_valid_r || a_load;

  // ---- combine pending bits with the held field ---------------------------
  logic [sbap_pkg::WIDTH_BITS-1:0] w_clamp;
  logic [sbap_pkg::VALUE_BITS-1:0] val_mask;
  logic [CW-1:0]                   combined;
  logic [SW-1:0]                   total;
  logic [PW-1:0]                   prod;
  logic [CNTW-1:0]                 nfull;
  logic [SW-1:0]                   used;
  logic [sbap_pkg::PCNT_BITS-1:0]  rem;
  logic                            has_part;
  logic [CNTW-1:0]                 nchar;
  logic [SW-1:0]                   lsh;
  logic [BUFW-1:0]                 aligned;
  logic [sbap_pkg::PEND_BITS-1:0]  rem_mask;

  always_comb begin
    if (a_width_r > sbap_pkg::WIDTH_BITS'(LIMIT)) begin
      w_clamp = sbap_pkg::WIDTH_BITS'(LIMIT);
    end else begin
      w_clamp = a_width_r;
    end
    val_mask = ~({sbap_pkg::VALUE_BITS{1'b1}} << w_clamp);
    combined = (CW'(pend_bits_r) << w_clamp) |
               CW'(a_value_r & val_mask);
    total    = SW'(pend_cnt_r) + SW'(w_clamp);
    prod     = PW'(total) * PW'(RECIP);
    nfull    = CNTW'(prod >> 8);
    used     = SW'(nfull) * SW'(G);
    rem      = sbap_pkg::PCNT_BITS'(total - used);
    has_part = a_final_r && (rem != '0);
    nchar    = nfull + CNTW'(has_part);
    // left-align so the first group sits at the top, pad bits fall in as zero
    lsh      = SW'(BUFW) - total;
    aligned  = BUFW'(combined) << lsh;
    rem_mask = ~({sbap_pkg::PEND_BITS{1'b1}} << rem);

    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (a_load) begin
      if (a_final_r) begin
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
      end else begin
        pend_bits_nxt = sbap_pkg::PEND_BITS'(combined) & rem_mask;
        pend_cnt_nxt  = rem;
      end
    end
  end

  // ---- control registers -----------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      b_left_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      if (a_load) begin
        b_left_r <= nchar;
      end else if (b_emit) begin
        b_left_r <= b_left_r - CNTW'(1);
      end
      if (b_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload registers -----------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_value_r <= in_field_value;
      a_width_r <= in_field_width;
      a_final_r <= in_final_field;
    end
    if (a_load) begin
      b_word_r  <= aligned;
      b_final_r <= a_final_r;
      b_fill_r  <= has_part ? sbap_pkg::FILL_BITS'(G - int'(rem)) : '0;
    end else if (b_emit) begin
      b_word_r  <= b_word_r << G;
    end
    if (b_emit) begin
      out_char_r <= sbap_pkg::armor(b_word_r[BUFW-1 -: G]);
      // last character of the item; message end only on a final field
      if (b_left_r == CNTW'(1)) begin
        out_end_r  <= b_final_r;
        out_fill_r <= b_final_r ? b_fill_r : '0;
      end else begin
        out_end_r  <= 1'b0;
        out_fill_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_armored_char = out_char_r;
  assign out_fill_bits    = out_fill_r;
  assign out_message_end  = out_end_r;

  // ---- assertions ------------------------------------------------------
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r < sbap_pkg::PCNT_BITS'(G))
    else $error("pending count out of range");

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_left_r <= CNTW'(NGRP))
    else $error("shifter character count out of range");

  a_fill_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_fill_r != '0)) |-> out_end_r)
    else $error("fill bits on a character that is not the message end");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r >= 7'd48 && out_char_r <= 7'd87) ||
                     (out_char_r >= 7'd96 && out_char_r <= 7'd119)))
    else $error("armored character out of range");

  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (a_load && a_final_r) |=> (pend_cnt_r == '0))
    else $error("partial group survived a final field");

endmodule
`default_nettype wire

### dv/six_bit_ascii_armor_packer_tb.sv
// ---------------------------------------------------------------------------
// six_bit_ascii_armor_packer_tb
// Drives bit fields into the armor packer and checks every character out.
// A short directed table walks the mapping limits, the zero and over-range
// widths, the flush and empty-final cases. Random messages of random fields
// follow. Results come from a local bit-accumulator model (typed directed
// rows: by hand), with random idling on both handshakes.
// ---------------------------------------------------------------------------
module six_bit_ascii_armor_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbap_pkg::*;

  // widths beyond this are clamped by the block
  localparam int CLAMP_BITS     = (DEF_MAX_FIELD_BITS < VALUE_BITS) ?
                                  DEF_MAX_FIELD_BITS : VALUE_BITS;
  localparam int RANDOM_ITEMS   = 450;
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES   = 20;    // quiet tail to catch stray characters
  localparam int NUM_DIRECTED   = 24;

  // one armored character as it leaves the block
  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic [FILL_BITS-1:0] fill;
    logic                 mend;
  } char_t;

  // directed row: the field, plus a hand-written expectation where it is
  // obvious (typed set). A typed row without has_char expects nothing.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [WIDTH_BITS-1:0] width;
    logic                  fin;
    logic                  typed;
    logic                  has_char;
    char_t                 exp;
  } field_row_t;

  localparam char_t NO_CHAR = '{7'd0, 3'd0, 1'b0};

  localparam field_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // single full groups at the ends of both halves of the armor map
    '{32'h0000_0000, 6'd6,  1'b1, 1'b1, 1'b1, '{7'd48,  3'd0, 1'b1}},
    '{32'h0000_003F, 6'd6,  1'b1, 1'b1, 1'b1, '{7'd119, 3'd0, 1'b1}},
    '{32'h0000_0027, 6'd6,  1'b1, 1'b1, 1'b1, '{7'd87,  3'd0, 1'b1}},
    '{32'h0000_0028, 6'd6,  1'b1, 1'b1, 1'b1, '{7'd96,  3'd0, 1'b1}},
    // one bit, five pad bits
    '{32'h0000_0001, 6'd1,  1'b1, 1'b1, 1'b1, '{7'd80,  3'd5, 1'b1}},
    // empty final: nothing pending, nothing completed, no character
    '{32'h0000_0000, 6'd0,  1'b1, 1'b1, 1'b0, NO_CHAR},
    // full-width field leaves two bits pending, zero-width final flushes them
    '{32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0, 1'b0, NO_CHAR},
    '{32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0, NO_CHAR},
    // over-range widths are clamped
    '{32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0, NO_CHAR},
    '{32'h1234_5678, 6'd33, 1'b0, 1'b0, 1'b0, NO_CHAR},
    // zero width mid-message does nothing
    '{32'hDEAD_BEEF, 6'd0,  1'b0, 1'b0, 1'b0, NO_CHAR},
    // total of 30 bits: message ends on a full character, no extra one
    '{32'hA5A5_A5A5, 6'd28, 1'b1, 1'b0, 1'b0, NO_CHAR},
    // a group built one bit at a time
    '{32'h0000_0001, 6'd1,  1'b0, 1'b0, 1'b0, NO_CHAR},
    '{32'h0000_0001, 6'd1,  1'b0, 1'b0, 1'b0, NO_CHAR},
    '{32'h0000_0001, 6'd1,  1'b0, 1'b0, 1'b0, NO_CHAR},
    '{32'h0000_0001, 6'd1,  1'b0, 1'b0, 1'b0, NO_CHAR},
    '{32'h0000_0001, 6'd1,  1'b0, 1'b0, 1'b0, NO_CHAR},
    '{32'h0000_0001, 6'd1,  1'b1, 1'b1, 1'b1, '{7'd119, 3'd0, 1'b1}},
    // five bits over two fields, one pad bit
    '{32'h0000_0003, 6'd2,  1'b0, 1'b0, 1'b0, NO_CHAR},
    '{32'h0000_0000, 6'd3,  1'b1, 1'b0, 1'b0, NO_CHAR},
    // top bit only, then close the group, then an empty final
    '{32'h8000_0000, 6'd32, 1'b0, 1'b0, 1'b0, NO_CHAR},
    '{32'h0000_0000, 6'd4,  1'b0, 1'b0, 1'b0, NO_CHAR},
    '{32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0, NO_CHAR},
    // five ones padded with one zero
    '{32'hFFFF_FFFF, 6'd5,  1'b1, 1'b1, 1'b1, '{7'd118, 3'd1, 1'b1}}
  };

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_field_value = '0;
  logic [WIDTH_BITS-1:0] in_field_width = '0;
  logic                  in_final_field = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [CHAR_BITS-1:0]  out_armored_char;
  logic [FILL_BITS-1:0]  out_fill_bits;
  logic                  out_message_end;

  // predictor state: the unfinished group carried between items
  logic [GROUP_BITS-1:0] grp_acc = '0;
  int                    grp_cnt = 0;

  char_t armor_q [$];      // characters still owed by the block, oldest first
  char_t oldest;
  int    errors       = 0;
  int    stall_left   = 0;
  int    quiet_cycles = 0;
  bit    no_idle      = 1'b0;  // both sides run flat out while set

  six_bit_ascii_armor_packer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_field_value   (in_field_value),
    .in_field_width   (in_field_width),
    .in_final_field   (in_final_field),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_armored_char (out_armored_char),
    .out_fill_bits    (out_fill_bits),
    .out_message_end  (out_message_end)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // values below the split land on '0'..'W', the rest on '`'..'w'
  function automatic logic [CHAR_BITS-1:0] to_armor_char(input logic [GROUP_BITS-1:0] grp);
    if (grp < ARMOR_SPLIT) begin
      return {1'b0, grp} + ARMOR_LOW;
    end
    return {1'b0, grp} + ARMOR_HIGH;
  endfunction

  // Shift one field into the accumulator, MSB first, and work out the
  // characters it completes. On a final field the partial group is padded
  // at the low end; if there is none, the last character of this field
  // takes the end mark instead. With keep clear only the state moves on.
  function automatic void pack_field(input logic [VALUE_BITS-1:0] value,
                                     input logic [WIDTH_BITS-1:0] width,
                                     input logic fin, input bit keep);
    char_t made [$];
    int    nbits;
    int    fill;
    nbits = (int'(width) > CLAMP_BITS) ? CLAMP_BITS : int'(width);
    for (int i = nbits - 1; i >= 0; i--) begin
      grp_acc = {grp_acc[GROUP_BITS-2:0], value[i]};
      grp_cnt++;
      if (grp_cnt == GROUP_BITS) begin
        made.push_back('{to_armor_char(grp_acc), 3'd0, 1'b0});
        grp_acc = '0;
        grp_cnt = 0;
      end
    end
    if (fin) begin
      if (grp_cnt > 0) begin
        fill = GROUP_BITS - grp_cnt;
        made.push_back('{to_armor_char(GROUP_BITS'(grp_acc << fill)), FILL_BITS'(fill), 1'b1});
      end else if (made.size() > 0) begin
        made[made.size()-1].fill = '0;
        made[made.size()-1].mend = 1'b1;
      end
      grp_acc = '0;
      grp_cnt = 0;
    end
    if (keep) begin
      foreach (made[k]) armor_q.push_back(made[k]);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // zero and over-range widths are rare but present
  function automatic logic [WIDTH_BITS-1:0] pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return WIDTH_BITS'($urandom_range(63, CLAMP_BITS + 1));
    return WIDTH_BITS'($urandom_range(CLAMP_BITS, 1));
  endfunction

  // hold the item until it is taken; returns at the accepting edge
  task automatic offer_field(input logic [VALUE_BITS-1:0] value,
                             input logic [WIDTH_BITS-1:0] width, input logic fin);
    in_valid       <= 1'b1;
    in_field_value <= value;
    in_field_width <= width;
    in_final_field <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  // Called at the accepting edge. Lowers valid at most once in this step;
  // with drain set, holds off until every owed character has come out.
  task automatic rest_sender(input bit drain);
    int gap;
    gap = pick_gap();
    // a hold-off always spans at least one edge
    if (drain && gap == 0) gap = 1;
    if (drain || gap > 0) begin
      in_valid       <= 1'b0;
      in_field_value <= $urandom;  // junk while idle must be ignored
      repeat (gap) @(posedge clk);
      if (drain) begin
        while (armor_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure, short stalls mostly, a few long ones
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (no_idle || $urandom_range(99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 0);
    end
  end

  // ---------------------------------------------------------------------
  // Checker: every accepted character against the oldest one owed
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (armor_q.size() == 0) begin
        $display("%0t: unexpected character: got char %0d fill %0d end %0b",
                 $time, out_armored_char, out_fill_bits, out_message_end);
        errors++;
      end else begin
        oldest = armor_q.pop_front();
        if (out_armored_char !== oldest.ch) begin
          $display("%0t: armored_char mismatch: expected %0d got %0d",
                   $time, oldest.ch, out_armored_char);
          errors++;
        end
        if (out_fill_bits !== oldest.fill) begin
          $display("%0t: fill_bits mismatch: expected %0d got %0d",
                   $time, oldest.fill, out_fill_bits);
          errors++;
        end
        if (out_message_end !== oldest.mend) begin
          $display("%0t: message_end mismatch: expected %0b got %0b",
                   $time, oldest.mend, out_message_end);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without a handshake on either side means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** six_bit_ascii_armor_packer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int                    sent;
    int                    nfields;
    logic [VALUE_BITS-1:0] value;
    logic [WIDTH_BITS-1:0] width;
    sent = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; the last row waits for the block to empty
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      offer_field(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].width, DIRECTED_ROWS[r].fin);
      pack_field(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].width, DIRECTED_ROWS[r].fin,
                 !DIRECTED_ROWS[r].typed);
      if (DIRECTED_ROWS[r].typed && DIRECTED_ROWS[r].has_char) begin
        armor_q.push_back(DIRECTED_ROWS[r].exp);
      end
      rest_sender(r == NUM_DIRECTED - 1);
    end

    // random messages: mostly a handful of fields, now and then a long run
    // so the accumulator carries across many items before the final flush
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 15) no_idle = ~no_idle;
      nfields = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(8, 1);
      for (int f = 0; f < nfields; f++) begin
        value = $urandom;
        width = pick_width();
        offer_field(value, width, f == nfields - 1);
        pack_field(value, width, f == nfields - 1, 1'b1);
        sent++;
        // one hold-off part way through, possibly mid-message
        rest_sender(sent == RANDOM_ITEMS / 2);
      end
    end

    in_valid <= 1'b0;
    while (armor_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("** six_bit_ascii_armor_packer: PASSED **");
    end else begin
      $display("** six_bit_ascii_armor_packer: FAILED **");
    end
    $finish;
  end

endmodule
